@@ hw/rtl/stta_pkg.sv @@
// Package: shared types and codes for the session table with idle aging.
`timescale 1ns / 1ps

package stta_pkg;

  localparam int TOKEN_W = 64;
  localparam int USER_W  = 32;
  localparam int ROLE_W  = 2;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 3'd0,
    CMD_VALIDATE = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_SWEEP    = 3'd3,
    CMD_COUNT    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic               valid;
    logic [TOKEN_W-1:0] tok_hi;
    logic [TOKEN_W-1:0] tok_lo;
    logic [USER_W-1:0]  user;
    logic [ROLE_W-1:0]  role;
    logic [TIME_W-1:0]  last;
  } entry_t;

endpackage

@@ hw/rtl/stta_if.sv @@
// Interfaces: command word channel and result word channel.
`timescale 1ns / 1ps

interface stta_in_if import stta_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [TOKEN_W-1:0] token_high;
  logic [TOKEN_W-1:0] token_low;
  logic [USER_W-1:0]  user_id;
  logic [ROLE_W-1:0]  user_role;
  logic [TIME_W-1:0]  now_seconds;

  modport source (output valid, cmd, token_high, token_low, user_id, user_role,
                  now_seconds, input ready);
  modport sink (input valid, cmd, token_high, token_low, user_id, user_role,
                now_seconds, output ready);
endinterface

interface stta_out_if import stta_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [USER_W-1:0]  found_user_id;
  logic [ROLE_W-1:0]  found_role;
  logic [TIME_W-1:0]  found_last_active;
  logic [COUNT_W-1:0] live_count;

  modport source (output valid, status, found_user_id, found_role,
                  found_last_active, live_count, input ready);
  modport sink (input valid, status, found_user_id, found_role,
                found_last_active, live_count, output ready);
endinterface

@@ hw/rtl/session_table_ttl_aging.sv @@
// Top level: session table keyed by 128-bit token, with idle-time aging.
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Word
// in_ch     in   valid/ready      cmd, token_high/low, user_id, user_role, now_seconds
// out_ch    out  valid/ready      status, found_user_id, found_role, found_last_active,
//                                 live_count
// cfg_*     in   cfg_we           cfg_wdata -> idle limit in seconds
//
// Create, validate, remove and sweep are accepted, then scanned through the table memory
// (one entry read per cycle, registered read data), then committed. Count and unused
// codes are accepted and then committed with no scan of the table memory.
// After reset a clearing pass zeroes the table; no word is taken.
// One command at a time; a result waits in the output register while the next
// command is scanned, and the commit stalls only if that result is still pending.

module session_table_ttl_aging
  import stta_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  stta_in_if.sink           in_ch,
  stta_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t state_r;

  // table memory
  entry_t mem [ENTRIES];
  entry_t rd_q;
  logic            wr_en;
  logic [IW-1:0]   wr_idx;
  entry_t          wr_data;

  // latched command
  logic [CMD_W-1:0]   cmd_r;
  logic [TOKEN_W-1:0] tok_hi_r, tok_lo_r;
  logic [USER_W-1:0]  user_r;
  logic [ROLE_W-1:0]  role_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  limit_r;

  // scan sequencer
  logic [IW-1:0] clr_idx_r;
  logic [IW-1:0] iss_r;
  logic          iss_done_r;
  logic          chk_vld_r;
  logic [IW-1:0] chk_idx_r;

  // scan findings
  logic              hit_r;
  logic [IW-1:0]     hit_idx_r;
  logic [USER_W-1:0] hit_user_r;
  logic [ROLE_W-1:0] hit_role_r;
  logic              hit_exp_r;
  logic              free_r;
  logic [IW-1:0]     free_idx_r;

  logic [CW-1:0] live_r;

  // result register
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic [USER_W-1:0]  out_user_r;
  logic [ROLE_W-1:0]  out_role_r;
  logic [TIME_W-1:0]  out_time_r;
  logic [COUNT_W-1:0] out_count_r;

  // shared compare unit on the entry under check
  logic [TIME_W-1:0] idle_time;
  logic chk_exp, chk_match, sweep_kill;

  assign idle_time  = now_r - rd_q.last;
  assign chk_exp    = idle_time > limit_r;
  assign chk_match  = rd_q.valid && (rd_q.tok_hi == tok_hi_r) && (rd_q.tok_lo == tok_lo_r);
  assign sweep_kill = chk_vld_r && (cmd_r == CMD_SWEEP) && rd_q.valid && chk_exp;

  // commit step
  logic              fin_go;
  logic              fin_wr_en;
  logic [IW-1:0]     fin_wr_idx;
  entry_t            fin_wr_data;
  logic [STAT_W-1:0] res_status;
  logic [USER_W-1:0] res_user;
  logic [ROLE_W-1:0] res_role;
  logic [TIME_W-1:0] res_time;
  logic [CW-1:0]     live_new;
  logic [LW-1:0]     live_ext;
  logic [COUNT_W-1:0] res_count;

  assign fin_go = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    res_status         = ST_OK;
    res_user           = '0;
    res_role           = '0;
    res_time           = '0;
    live_new           = live_r;
    fin_wr_en          = 1'b0;
    fin_wr_idx         = hit_idx_r;
    fin_wr_data.valid  = 1'b1;
    fin_wr_data.tok_hi = tok_hi_r;
    fin_wr_data.tok_lo = tok_lo_r;
    fin_wr_data.user   = user_r;
    fin_wr_data.role   = role_r;
    fin_wr_data.last   = now_r;
    unique case (cmd_r)
      CMD_CREATE: begin
        if (hit_r) begin
          fin_wr_en = 1'b1;
        end else if (free_r) begin
          fin_wr_en  = 1'b1;
          fin_wr_idx = free_idx_r;
          live_new   = live_r + CW'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_VALIDATE: begin
        if (!hit_r) begin
          res_status = ST_MISSING;
        end else if (hit_exp_r) begin
          fin_wr_en         = 1'b1;
          fin_wr_data.valid = 1'b0;
          live_new          = live_r - CW'(1);
          res_status        = ST_EXPIRED;
        end else begin
          // refresh time, keep stored user and role
          fin_wr_en        = 1'b1;
          fin_wr_data.user = hit_user_r;
          fin_wr_data.role = hit_role_r;
          res_user         = hit_user_r;
          res_role         = hit_role_r;
          res_time         = now_r;
        end
      end
      CMD_REMOVE: begin
        if (!hit_r) begin
          res_status = ST_MISSING;
        end else begin
          fin_wr_en         = 1'b1;
          fin_wr_data.valid = 1'b0;
          live_new          = live_r - CW'(1);
        end
      end
      default: begin
      end
    endcase
    live_ext  = LW'(live_new);
    res_count = (live_ext > LW'(31)) ? COUNT_W'(31) : live_ext[COUNT_W-1:0];
  end

  // memory write port select
  always_comb begin
    wr_en         = 1'b0;
    wr_idx        = chk_idx_r;
    wr_data       = rd_q;
    wr_data.valid = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_idx  = clr_idx_r;
        wr_data = '0;
      end
      S_SCAN: begin
        wr_en = sweep_kill;
      end
      S_FINISH: begin
        wr_en   = fin_go && fin_wr_en;
        wr_idx  = fin_wr_idx;
        wr_data = fin_wr_data;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q <= mem[iss_r];
  end

  // sequencer, findings and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      iss_r       <= '0;
      iss_done_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      live_r      <= '0;
      limit_r     <= TIME_W'(1800);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      // a commit in the same cycle reloads the result register instead
      if (out_valid_r && out_ch.ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + IW'(1);
          if (clr_idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            cmd_r      <= in_ch.cmd;
            tok_hi_r   <= in_ch.token_high;
            tok_lo_r   <= in_ch.token_low;
            user_r     <= in_ch.user_id;
            role_r     <= in_ch.user_role;
            now_r      <= in_ch.now_seconds;
            hit_r      <= 1'b0;
            free_r     <= 1'b0;
            iss_r      <= '0;
            iss_done_r <= 1'b0;
            chk_vld_r  <= 1'b0;
            unique case (in_ch.cmd) inside
              CMD_CREATE, CMD_VALIDATE, CMD_REMOVE, CMD_SWEEP: state_r <= S_SCAN;
              default:                                         state_r <= S_FINISH;
            endcase
          end
        end
        S_SCAN: begin
          // issue side: one read address per cycle
          if (!iss_done_r) begin
            chk_vld_r <= 1'b1;
            chk_idx_r <= iss_r;
            if (iss_r == LAST_IDX) begin
              iss_done_r <= 1'b1;
            end else begin
              iss_r <= iss_r + IW'(1);
            end
          end else begin
            chk_vld_r <= 1'b0;
          end
          // check side: entry read last cycle
          if (chk_vld_r) begin
            if (chk_match && !hit_r) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= chk_idx_r;
              hit_user_r <= rd_q.user;
              hit_role_r <= rd_q.role;
              hit_exp_r  <= chk_exp;
            end
            if (!rd_q.valid && !free_r) begin
              free_r     <= 1'b1;
              free_idx_r <= chk_idx_r;
            end
            if (sweep_kill) begin
              live_r <= live_r - CW'(1);
            end
            if (chk_idx_r == LAST_IDX) begin
              state_r <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (fin_go) begin
            live_r       <= live_new;
            out_valid_r  <= 1'b1;
            out_status_r <= res_status;
            out_user_r   <= res_user;
            out_role_r   <= res_role;
            out_time_r   <= res_time;
            out_count_r  <= res_count;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.found_user_id     = out_user_r;
  assign out_ch.found_role        = out_role_r;
  assign out_ch.found_last_active = out_time_r;
  assign out_ch.live_count        = out_count_r;

endmodule
